// ----- hw/rtl/asort_pkg.sv -----
// shared types and constants of the ascending sorter
package asort_pkg;

    localparam int unsigned ValueWidth      = 32;
    localparam int unsigned AsMaxElements   = 16;

    typedef logic signed [ValueWidth-1:0] t_value;

    // input item
    typedef struct packed {
        t_value value;
        logic   last;
    } t_in_item;

    // result item
    typedef struct packed {
        t_value sorted_value;
        logic   final_res;
    } t_out_item;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   occupied;
        logic   lt;
        t_value value;
    } t_link;

endpackage

// ----- hw/rtl/asort_stream_if.sv -----
// valid/ready channel carrying one item
interface asort_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/asort_cell.sv -----
// one cell of the insertion chain: holds one element of the set
module asort_cell
    import asort_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_insert,
    input  logic   i_shift_out,
    input  t_value i_new_value,
    input  t_link  i_left,
    input  t_link  i_right,
    output t_link  o_link
);

    logic   r_valid;
    t_value r_value;
    logic   n_valid;
    t_value n_value;
    logic   lt;

    // new element goes at or before this cell
    assign lt = !r_valid || (i_new_value < r_value);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_shift_out) begin
            n_valid = i_right.occupied;
            n_value = i_right.value;
        end else if (i_insert && lt) begin
            n_valid = i_left.occupied;
            n_value = (i_left.occupied && i_left.lt) ? i_left.value : i_new_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.occupied = r_valid;
    assign o_link.lt       = lt;
    assign o_link.value    = r_value;

endmodule

// ----- hw/rtl/ascending_sorter_core.sv -----
// top level of the ascending sorter: a chain of insertion cells
// A set is loaded one item per cycle: each item is inserted into its sorted place in a
// chain of MAX_ELEMENTS cells in the cycle it is accepted. The item flagged last starts
// the readout, which shifts the chain toward cell 0 and delivers one result per cycle
// while the output is ready, smallest first. Input is held off during readout.
// Items beyond MAX_ELEMENTS are dropped, but a dropped item flagged last still ends
// the set.
module ascending_sorter_core
    import asort_pkg::*;
#(
    parameter int unsigned MAX_ELEMENTS = AsMaxElements
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    asort_stream_if.sink   i_in,
    asort_stream_if.source o_out
);

    t_link                   links [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] occ;
    t_link                   head_link;
    t_link                   tail_link;
    logic                    r_emitting;
    logic                    in_accept;
    logic                    out_accept;
    logic                    insert;
    logic                    shift_out;
    t_in_item                in_item;

    assign in_item    = i_in.data;
    assign i_in.ready = !r_emitting;
    assign in_accept  = i_in.valid && i_in.ready;
    assign insert     = in_accept && !occ[MAX_ELEMENTS-1];
    assign out_accept = o_out.valid && o_out.ready;
    assign shift_out  = out_accept;

    // cell 0 always takes the new element when it is smaller
    assign head_link.occupied = 1'b1;
    assign head_link.lt       = 1'b0;
    assign head_link.value    = '0;

    assign tail_link.occupied = 1'b0;
    assign tail_link.lt       = 1'b1;
    assign tail_link.value    = '0;

    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        t_link left;
        t_link right;

        if (g == 0) begin : g_head
            assign left = head_link;
        end else begin : g_body_l
            assign left = links[g-1];
        end

        if (g == MAX_ELEMENTS - 1) begin : g_tail
            assign right = tail_link;
        end else begin : g_body_r
            assign right = links[g+1];
        end

        asort_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_insert    (insert),
            .i_shift_out (shift_out),
            .i_new_value (in_item.value),
            .i_left      (left),
            .i_right     (right),
            .o_link      (links[g])
        );

        assign occ[g] = links[g].occupied;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emitting <= 1'b0;
        end else if (in_accept && in_item.last) begin
            r_emitting <= 1'b1;
        end else if (out_accept && !occ[1]) begin
            r_emitting <= 1'b0;
        end
    end

    assign o_out.valid             = r_emitting && occ[0];
    assign o_out.data.sorted_value = links[0].value;
    assign o_out.data.final_res    = !occ[1];

    // occupied cells always form a prefix of the chain
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((occ >> 1) & ~occ) == '0)
        else $error("occupied cells are not a prefix of the chain");

    // a set always holds at least one element when readout starts
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_item.last) |=> o_out.valid)
        else $error("readout started with an empty chain");

    // the final result leaves the chain empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_accept && o_out.data.final_res) |=> (!o_out.valid && occ == '0))
        else $error("elements left after the final result");

endmodule
